/* design/fsp2_pkg.sv */
// Package for the floating-point power-of-two scaling core.
// Holds format defaults and shared types; no dependencies.
`timescale 1ns / 1ps
package fsp2_pkg;
	localparam int unsigned DEF_EXP_BITS = 11;
	localparam int unsigned DEF_FRAC_BITS = 52;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned SCALE_W = 14;
	// Wide enough for a biased exponent plus any scale and normalisation shift.
	localparam int unsigned EXPS_W = 16;

	typedef enum logic [1:0] {
		KIND_PASS,
		KIND_OVF,
		KIND_NORM,
		KIND_SUB
	} kind_t;
endpackage

/* design/fsp2_norm.sv */
// Stage one: unpacks the operand, classifies it and counts leading zeros of a subnormal.
// Depends on fsp2_pkg.
`timescale 1ns / 1ps
module fsp2_norm import fsp2_pkg::*; #(
	parameter int unsigned EXP_BITS = DEF_EXP_BITS,
	parameter int unsigned FRAC_BITS = DEF_FRAC_BITS,
	localparam int unsigned LZ_W = $clog2(FRAC_BITS + 1)
) (
	input  logic [VALUE_W-1:0]   value,
	input  logic signed [SCALE_W-1:0] scale,
	output logic                 pass,
	output logic                 sign,
	output logic [EXP_BITS-1:0]  exp_field,
	output logic [FRAC_BITS-1:0] frac,
	output logic [LZ_W-1:0]      lz
);
	always_comb begin
		sign = value[EXP_BITS+FRAC_BITS];
		exp_field = value[FRAC_BITS +: EXP_BITS];
		frac = value[FRAC_BITS-1:0];
		pass = (&exp_field) || (exp_field == '0 && frac == '0) || scale == '0;
		lz = '0;
		for (int i = 0; i < FRAC_BITS; i++) begin
			if (frac[i])
				lz = LZ_W'(FRAC_BITS - i);
		end
	end
endmodule

/* design/fsp2_round.sv */
// Stage three: denormalises a significand by a right shift and rounds to nearest even.
// Depends on fsp2_pkg.
`timescale 1ns / 1ps
module fsp2_round import fsp2_pkg::*; #(
	parameter int unsigned FRAC_BITS = DEF_FRAC_BITS,
	localparam int unsigned SH_W = $clog2(FRAC_BITS + 3)
) (
	input  logic [FRAC_BITS:0] mant,
	input  logic [SH_W-1:0]    shift,
	output logic [FRAC_BITS:0] q
);
	logic [2*FRAC_BITS+1:0] ext;
	logic [FRAC_BITS:0] rem, half, base;
	always_comb begin
		ext = {mant, {(FRAC_BITS+1){1'b0}}} >> shift;
		base = ext[2*FRAC_BITS+1 -: FRAC_BITS+1];
		rem = ext[FRAC_BITS:0];
		half = {1'b1, {FRAC_BITS{1'b0}}};
		q = base;
		if (rem > half || (rem == half && base[0]))
			q = base + 1'b1;
	end
endmodule

/* design/fp_scale_by_power_of_two_core.sv */
// Top level of the floating-point power-of-two scaling core.
// Instantiates fsp2_norm and fsp2_round; depends on fsp2_pkg.
// The core takes one operand pair per cycle while the output side accepts results and returns
// value times two to scale after three register stages (classify, normalise and add exponent,
// round and assemble); valid bits travel with each stage and a stall on the output freezes
// the whole pipeline without losing or repeating a transfer.
`timescale 1ns / 1ps
module fp_scale_by_power_of_two_core import fsp2_pkg::*; #(
	parameter int unsigned EXP_BITS = DEF_EXP_BITS,
	parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_in,
	output logic                      ready_in,
	input  logic [VALUE_W-1:0]        value,
	input  logic signed [SCALE_W-1:0] scale,
	output logic                      valid_out,
	input  logic                      ready_out,
	output logic [VALUE_W-1:0]        result,
	output logic                      overflow,
	output logic                      underflow
);
	localparam int unsigned TOT = 1 + EXP_BITS + FRAC_BITS;
	localparam int unsigned LZ_W = $clog2(FRAC_BITS + 1);
	localparam int unsigned SH_W = $clog2(FRAC_BITS + 3);
	localparam logic signed [EXPS_W-1:0] EMAX = EXPS_W'((1 << EXP_BITS) - 1);

	logic adv;
	assign adv = ready_out || !valid_out;
	assign ready_in = adv;

	logic n_pass, n_sign;
	logic [EXP_BITS-1:0] n_exp;
	logic [FRAC_BITS-1:0] n_frac;
	logic [LZ_W-1:0] n_lz;

	fsp2_norm #(.EXP_BITS(EXP_BITS), .FRAC_BITS(FRAC_BITS)) u_norm (
		.value(value), .scale(scale), .pass(n_pass), .sign(n_sign),
		.exp_field(n_exp), .frac(n_frac), .lz(n_lz)
	);

	logic v_s1, pass_s1, sign_s1;
	logic [TOT-1:0] word_s1;
	logic [EXP_BITS-1:0] exp_s1;
	logic [FRAC_BITS-1:0] frac_s1;
	logic [LZ_W-1:0] lz_s1;
	logic signed [SCALE_W-1:0] scale_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= valid_in;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s1 <= n_pass;
			sign_s1 <= n_sign;
			word_s1 <= value[TOT-1:0];
			exp_s1 <= n_exp;
			frac_s1 <= n_frac;
			lz_s1 <= n_lz;
			scale_s1 <= scale;
		end
	end

	// Stage two: normalise and add the scale.
	logic signed [EXPS_W-1:0] ne;
	logic [FRAC_BITS:0] mant;
	kind_t kind;
	logic [SH_W-1:0] shv;
	logic signed [EXPS_W-1:0] sdiff;
	always_comb begin
		if (exp_s1 == '0) begin
			mant = {1'b0, frac_s1} << lz_s1;
			ne = EXPS_W'(scale_s1) + 16'sd1 - EXPS_W'(lz_s1);
		end else begin
			mant = {1'b1, frac_s1};
			ne = EXPS_W'(scale_s1) + EXPS_W'({1'b0, exp_s1});
		end
		sdiff = 16'sd1 - ne;
		shv = (sdiff > EXPS_W'(FRAC_BITS + 2)) ? SH_W'(FRAC_BITS + 2) : SH_W'(sdiff);
		if (pass_s1)
			kind = KIND_PASS;
		else if (ne >= EMAX)
			kind = KIND_OVF;
		else if (ne >= 16'sd1)
			kind = KIND_NORM;
		else
			kind = KIND_SUB;
	end

	logic v_s2, sign_s2;
	kind_t kind_s2;
	logic [TOT-1:0] word_s2;
	logic [EXP_BITS-1:0] ne_s2;
	logic [FRAC_BITS:0] mant_s2;
	logic [SH_W-1:0] sh_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sign_s2 <= sign_s1;
			kind_s2 <= kind;
			word_s2 <= word_s1;
			ne_s2 <= ne[EXP_BITS-1:0];
			mant_s2 <= mant;
			sh_s2 <= shv;
		end
	end

	// Stage three: round a subnormal result and assemble.
	logic [FRAC_BITS:0] q;
	fsp2_round #(.FRAC_BITS(FRAC_BITS)) u_round (.mant(mant_s2), .shift(sh_s2), .q(q));

	logic [TOT-1:0] res;
	logic ovf, unf;
	always_comb begin
		ovf = 1'b0;
		unf = 1'b0;
		case (kind_s2)
			KIND_PASS: res = word_s2;
			KIND_OVF: begin
				res = {sign_s2, {EXP_BITS{1'b1}}, {FRAC_BITS{1'b0}}};
				ovf = 1'b1;
			end
			KIND_NORM: res = {sign_s2, ne_s2, mant_s2[FRAC_BITS-1:0]};
			default: begin
				res = {sign_s2, {(EXP_BITS-1){1'b0}}, q};
				unf = (q == '0);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_out <= 1'b0;
		else if (adv)
			valid_out <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			result <= VALUE_W'(res);
			overflow <= ovf;
			underflow <= unf;
		end
	end
endmodule
